### rtl/lawd_pkg.sv
package lawd_pkg;

  // Fixed field widths
  localparam int MASK_W   = 32;
  localparam int IDX_W    = 3;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;

  localparam int DEF_NUM_WORKERS = 8;
  localparam int DEF_NUM_VARS    = 32;

  // Request types
  localparam logic REQ_SCHEDULE = 1'b0;
  localparam logic REQ_RELEASE  = 1'b1;

  // Lock modes (code 3 acts as no locking)
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RW    = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_IDLE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd3;

  typedef struct packed {
    logic              valid;
    logic              req_type;
    logic [MASK_W-1:0] read_mask;
    logic [MASK_W-1:0] write_mask;
    logic [IDX_W-1:0]  release_worker;
  } lawd_req_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    worker;
  } lawd_res_t;

endpackage

### rtl/lawd_pool.sv
module lawd_pool #(
  parameter int NUM_WORKERS = lawd_pkg::DEF_NUM_WORKERS,
  parameter int NUM_VARS    = lawd_pkg::DEF_NUM_VARS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lawd_pkg::MODE_W-1:0] lock_mode,
  input  lawd_pkg::lawd_req_t         req,
  output lawd_pkg::lawd_res_t         res
);
  import lawd_pkg::*;

  localparam int WIDX   = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int LOCK_W = (NUM_VARS < MASK_W) ? NUM_VARS : MASK_W;

  // Busy flags act as valid bits for the lock sets: an idle worker holds nothing.
  logic [NUM_WORKERS-1:0] busy_q;
  logic [LOCK_W-1:0]      locks [NUM_WORKERS];

  logic [LOCK_W-1:0] rd_m, wr_m, held, need;
  logic [WIDX-1:0]   pick;
  logic              any_idle;
  logic              rel_ok;
  logic [WIDX-1:0]   rel_idx;
  logic              do_grant;

  assign rd_m    = LOCK_W'(req.read_mask);
  assign wr_m    = LOCK_W'(req.write_mask);
  assign rel_ok  = (32'(req.release_worker) < 32'(NUM_WORKERS));
  assign rel_idx = WIDX'(req.release_worker);

  // Lowest-numbered idle worker
  always_comb begin
    pick     = '0;
    any_idle = 1'b0;
    for (int w = NUM_WORKERS - 1; w >= 0; w--) begin
      if (!busy_q[w]) begin
        pick     = WIDX'(w);
        any_idle = 1'b1;
      end
    end
  end

  always_comb begin
    held = '0;
    for (int w = 0; w < NUM_WORKERS; w++) begin
      held = held | (locks[w] & {LOCK_W{busy_q[w]}});
    end
  end

  always_comb begin
    unique case (lock_mode)
      MODE_RW:    need = rd_m | wr_m;
      MODE_WRITE: need = wr_m;
      default:    need = '0;
    endcase
  end

  always_comb begin
    res.valid  = req.valid;
    res.worker = '0;
    do_grant   = 1'b0;
    priority if (req.req_type == REQ_RELEASE) begin
      res.status = ST_RELEASED;
    end else if (!any_idle) begin
      res.status = ST_NO_IDLE;
    end else if ((held & need) != '0) begin
      res.status = ST_CONFLICT;
    end else begin
      res.status = ST_GRANTED;
      res.worker = IDX_W'(pick);
      do_grant   = req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= '0;
    end else if (req.valid) begin
      if (req.req_type == REQ_RELEASE) begin
        if (rel_ok) begin
          busy_q[rel_idx] <= 1'b0;
        end
      end else if (do_grant) begin
        busy_q[pick] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_grant) begin
      locks[pick] <= wr_m;
    end
  end

  a_grant_marks_busy: assert property (@(posedge clk) disable iff (rst)
    do_grant |=> busy_q[$past(pick)])
    else $error("granted worker not busy afterwards");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.req_type == REQ_RELEASE && rel_ok) |=> !busy_q[$past(rel_idx)])
    else $error("released worker still busy");

  a_grant_idle_only: assert property (@(posedge clk) disable iff (rst)
    do_grant |-> !busy_q[pick])
    else $error("grant to a busy worker");

endmodule

### rtl/lock_aware_worker_dispatcher_core.sv
// Lock-aware worker dispatcher.
// Requests arrive on start with req_type, read_mask, write_mask and
// release_worker; one is taken at every clock edge where start is high and
// busy is low. busy is never raised, so a request may be issued every cycle.
// A schedule request goes to the lowest-numbered idle worker unless none is
// idle or its masks clash with write locks held by busy workers (per
// lock_mode). A release request frees the named worker.
// Every request gives exactly one result beat: done is high for one cycle
// with status and granted_worker. From accept, a request passes through the
// request register, then through the pick/conflict logic into the result
// register. Throughput is one request per cycle; the worker table updates at
// the same edge as the result, so the next request sees it.
// lock_mode is written on the cfg channel (cfg_ready always high); the user
// must write it only while no request is in flight, as the block itself does
// not enforce this. Reset clears all workers to idle, lock_mode to
// read-write locking, and drops any request in flight.
// The receiver cannot stall: done is a one-cycle strobe.
module lock_aware_worker_dispatcher_core #(
  parameter int NUM_WORKERS = lawd_pkg::DEF_NUM_WORKERS,
  parameter int NUM_VARS    = lawd_pkg::DEF_NUM_VARS
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [lawd_pkg::MASK_W-1:0]   read_mask,
  input  logic [lawd_pkg::MASK_W-1:0]   write_mask,
  input  logic [lawd_pkg::IDX_W-1:0]    release_worker,
  // config channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lawd_pkg::MODE_W-1:0]   cfg_data,
  // result channel
  output logic                          done,
  output logic [lawd_pkg::STATUS_W-1:0] status,
  output logic [lawd_pkg::IDX_W-1:0]    granted_worker
);
  import lawd_pkg::*;

  logic [MODE_W-1:0] lock_mode;
  lawd_req_t         req_q;
  lawd_res_t         res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_mode <= MODE_RW;
    end else if (cfg_valid && cfg_ready) begin
      lock_mode <= cfg_data;
    end
  end

  // Request register: valid is control, payload is not reset
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q.valid <= 1'b0;
    end else begin
      req_q.valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q.req_type       <= req_type;
      req_q.read_mask      <= read_mask;
      req_q.write_mask     <= write_mask;
      req_q.release_worker <= release_worker;
    end
  end

  lawd_pool #(
    .NUM_WORKERS (NUM_WORKERS),
    .NUM_VARS    (NUM_VARS)
  ) u_pool (
    .clk       (clk),
    .rst       (rst),
    .lock_mode (lock_mode),
    .req       (req_q),
    .res       (res)
  );

  // Result register: one done beat per request
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status         <= res.status;
      granted_worker <= res.worker;
    end
  end

  a_one_beat_per_req: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) ##1 !rst |=> done)
    else $error("request without result beat");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(req_q.valid))
    else $error("result beat without request");

  a_worker_zero_unless_granted: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_GRANTED) |-> granted_worker == '0)
    else $error("worker index on a refused request");

endmodule

### verif/tb_lock_aware_worker_dispatcher_core.sv
module tb_lock_aware_worker_dispatcher_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lawd_pkg::*;

  // Pool geometry follows the package defaults the block is built with
  localparam int NW = DEF_NUM_WORKERS;
  localparam int NV = DEF_NUM_VARS;
  // Mask bits at or above NV are dropped by the block, never stored
  localparam logic [MASK_W-1:0] VAR_KEEP = (NV >= MASK_W) ? '1 : MASK_W'((64'd1 << NV) - 1);

  // Code 3 is not a defined mode; it must act as no locking
  localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

  localparam realtime CLK_PERIOD   = 12ns;
  localparam int      RESET_CYCLES = 6;
  // Drain margin after the last expected result beat
  localparam int      DRAIN_CYCLES = 4;
  localparam int      LAST_WAIT    = 1000;
  // Slowest legal run is well under half a millisecond; take it several times over
  localparam realtime RUN_LIMIT    = 3ms;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    worker;
  } outcome_t;

  typedef struct packed {
    logic [MODE_W-1:0] lock_mode;   // mode to be in before the beat goes out
    logic              req;
    logic [MASK_W-1:0] rd;
    logic [MASK_W-1:0] wr;
    logic [IDX_W-1:0]  rel;
    logic              typed;       // expectation written in by hand
    outcome_t          expected;
  } stim_row_t;

  // Every input known from time zero
  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              start          = 1'b0;
  logic              req_type       = REQ_SCHEDULE;
  logic [MASK_W-1:0] read_mask      = '0;
  logic [MASK_W-1:0] write_mask     = '0;
  logic [IDX_W-1:0]  release_worker = '0;
  logic              cfg_valid      = 1'b0;
  logic [MODE_W-1:0] cfg_data       = MODE_RW;

  logic                busy;
  logic                cfg_ready;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    granted_worker;

  lock_aware_worker_dispatcher_core dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .read_mask      (read_mask),
    .write_mask     (write_mask),
    .release_worker (release_worker),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .granted_worker (granted_worker)
  );

  // Shadow of the worker table and the lock mode, updated in accept order
  bit                cur_busy   [NW];
  logic [MASK_W-1:0] cur_locks  [NW];
  logic [MODE_W-1:0] cur_mode;

  outcome_t  pending_outcomes[$];
  stim_row_t directed_rows[$];
  int        err_cnt = 0;

  initial begin
    forever begin
      #(CLK_PERIOD / 2) clk = ~clk;
    end
  end

  // Hard stop, in case the block hangs or drops result beats
  initial begin
    #(RUN_LIMIT);
    $display("lock_aware_worker_dispatcher_core test failed");
    $finish;
  end

  // Expected outcome of one accepted request; moves the shadow table on
  function automatic outcome_t dispatch_outcome(logic req, logic [MASK_W-1:0] rd,
                                                logic [MASK_W-1:0] wr, logic [IDX_W-1:0] rel);
    outcome_t          o;
    logic [MASK_W-1:0] rd_k, wr_k, held, need;
    int                pick, w;
    o.status = ST_RELEASED;
    o.worker = '0;
    rd_k = rd & VAR_KEEP;
    wr_k = wr & VAR_KEEP;
    if (req == REQ_RELEASE) begin
      // Out of range or idle: still a release beat, idle worker's locks cleared
      if (int'(rel) < NW) begin
        cur_busy[rel]  = 1'b0;
        cur_locks[rel] = '0;
      end
      return o;
    end
    pick = -1;
    held = '0;
    for (w = NW - 1; w >= 0; w--) begin
      if (!cur_busy[w]) pick = w;
      held |= cur_locks[w];
    end
    if (pick < 0) begin
      o.status = ST_NO_IDLE;
      return o;
    end
    case (cur_mode)
      MODE_RW:    need = rd_k | wr_k;
      MODE_WRITE: need = wr_k;
      default:    need = '0;      // no locking, and the undefined code
    endcase
    if ((held & need) != '0) begin
      o.status = ST_CONFLICT;
      return o;
    end
    cur_busy[pick]  = 1'b1;
    cur_locks[pick] = wr_k;
    o.status = ST_GRANTED;
    o.worker = IDX_W'(pick);
    return o;
  endfunction

  function automatic stim_row_t mk_row(logic [MODE_W-1:0] mode, logic req,
                                       logic [MASK_W-1:0] rd, logic [MASK_W-1:0] wr,
                                       logic [IDX_W-1:0] rel, logic typed,
                                       logic [STATUS_W-1:0] st, logic [IDX_W-1:0] wk);
    stim_row_t r;
    r.lock_mode       = mode;
    r.req             = req;
    r.rd              = rd;
    r.wr              = wr;
    r.rel             = rel;
    r.typed           = typed;
    r.expected.status = st;
    r.expected.worker = wk;
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Mostly sparse masks so grants keep coming; some dense and full ones
  function automatic logic [MASK_W-1:0] random_mask();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3, 4: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      5:       return (MASK_W'(1) << $urandom_range(0, MASK_W - 1))
                    | (MASK_W'(1) << $urandom_range(0, MASK_W - 1));
      6, 7:    return $urandom;
      8:       return '1;
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  // One request beat: hold it until the block takes it, then predict
  task automatic issue(stim_row_t r);
    outcome_t predicted;
    start          <= 1'b1;
    req_type       <= r.req;
    read_mask      <= r.rd;
    write_mask     <= r.wr;
    release_worker <= r.rel;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = dispatch_outcome(r.req, r.rd, r.wr, r.rel);
    pending_outcomes.insert(pending_outcomes.size(), r.typed ? r.expected : predicted);
  endtask

  // Stop sending and let every outstanding beat come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_lock_mode(logic [MODE_W-1:0] mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_mode = mode;
  endtask

  // Random phase under one lock mode
  task automatic run_phase(logic [MODE_W-1:0] mode, int count, bit idling);
    stim_row_t r;
    int        n, k, pick, seen;
    bit        idle_on;
    drain_results();
    write_lock_mode(mode);
    idle_on = 1'b1;
    for (n = 0; n < count; n++) begin
      // idling switched on and off in stretches of 64 beats
      if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (idling && idle_on && $urandom_range(0, 4) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      r = mk_row(mode, ($urandom_range(0, 9) < 4) ? REQ_RELEASE : REQ_SCHEDULE,
                 random_mask(), random_mask(), IDX_W'($urandom), 1'b0, ST_GRANTED, '0);
      // most releases free a worker that really is busy, else the pool clogs
      if (r.req == REQ_RELEASE && $urandom_range(0, 4) != 0) begin
        seen = 0;
        for (k = 0; k < NW; k++) if (cur_busy[k]) seen++;
        if (seen != 0) begin
          pick = $urandom_range(0, seen - 1);
          for (k = 0; k < NW; k++) begin
            if (cur_busy[k]) begin
              if (pick == 0) r.rel = IDX_W'(k);
              pick--;
            end
          end
        end
      end
      issue(r);
    end
  endtask

  // Result checker: done is a one-cycle strobe, sampled at the edge ending it
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with nothing expected: status %0d granted_worker %0d",
               status, granted_worker);
        err_cnt++;
      end else begin
        if (status !== pending_outcomes[0].status) begin
          $error("status: expected %0d, got %0d", pending_outcomes[0].status, status);
          err_cnt++;
        end
        if (granted_worker !== pending_outcomes[0].worker) begin
          $error("granted_worker: expected %0d, got %0d",
                 pending_outcomes[0].worker, granted_worker);
          err_cnt++;
        end
        void'(pending_outcomes.pop_front());
      end
    end
  end

  initial begin
    int n;
    bit lost;

    // Shadow state as after reset
    cur_mode = MODE_RW;
    for (n = 0; n < NW; n++) begin
      cur_busy[n]  = 1'b0;
      cur_locks[n] = '0;
    end

    // Directed table. Starts in reset mode (read-write) and walks the pool
    // through grant, conflict, full pool and every lock mode.
    // grab all variables for writing on worker 0
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, '0, '1, 3'd0, 1'b1, ST_GRANTED, 3'd0));
    // a read of a written variable clashes in read-write mode
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, 32'h0000_0001, '0, 3'd0,
                   1'b1, ST_CONFLICT, 3'd0));
    // empty masks never clash
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, '0, '0, 3'd0, 1'b1, ST_GRANTED, 3'd1));
    // release of an idle worker, top index
    add_row(mk_row(MODE_RW, REQ_RELEASE, '0, '0, 3'd7, 1'b1, ST_RELEASED, 3'd0));
    add_row(mk_row(MODE_RW, REQ_RELEASE, '1, '1, 3'd0, 1'b1, ST_RELEASED, 3'd0));
    // locks gone, so a full read mask is fine now
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, '1, '0, 3'd0, 1'b1, ST_GRANTED, 3'd0));
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, '0, '0, 3'd0, 1'b1, ST_GRANTED, 3'd2));
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, 32'hAAAA_AAAA, '0, 3'd0,
                   1'b1, ST_GRANTED, 3'd3));
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, 32'h5555_5555, '0, 3'd0,
                   1'b1, ST_GRANTED, 3'd4));
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, '0, '0, 3'd0, 1'b1, ST_GRANTED, 3'd5));
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, '0, '0, 3'd0, 1'b1, ST_GRANTED, 3'd6));
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, '0, '0, 3'd0, 1'b1, ST_GRANTED, 3'd7));
    // pool full
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, '1, '1, 3'd0, 1'b1, ST_NO_IDLE, 3'd0));
    add_row(mk_row(MODE_RW, REQ_RELEASE, '0, '0, 3'd3, 1'b1, ST_RELEASED, 3'd0));
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, 32'h0000_0001, 32'h8000_0000, 3'd0,
                   1'b1, ST_GRANTED, 3'd3));
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, 32'hAAAA_AAAA, 32'h5555_5555, 3'd0,
                   1'b1, ST_NO_IDLE, 3'd0));
    add_row(mk_row(MODE_RW, REQ_RELEASE, '0, '0, 3'd5, 1'b1, ST_RELEASED, 3'd0));
    // read of the top variable, held for writing by worker 3
    add_row(mk_row(MODE_RW, REQ_SCHEDULE, 32'h8000_0000, '0, 3'd0,
                   1'b1, ST_CONFLICT, 3'd0));
    // write-only locking lets the same read through
    add_row(mk_row(MODE_WRITE, REQ_SCHEDULE, 32'h8000_0000, '0, 3'd0,
                   1'b1, ST_GRANTED, 3'd5));
    add_row(mk_row(MODE_WRITE, REQ_RELEASE, '0, '0, 3'd6, 1'b1, ST_RELEASED, 3'd0));
    // but a write against a held write still clashes
    add_row(mk_row(MODE_WRITE, REQ_SCHEDULE, '0, 32'h8000_0000, 3'd0,
                   1'b1, ST_CONFLICT, 3'd0));
    // no locking: anything goes
    add_row(mk_row(MODE_NONE, REQ_SCHEDULE, '1, '1, 3'd0, 1'b1, ST_GRANTED, 3'd6));
    // undefined mode code behaves as no locking
    add_row(mk_row(MODE_UNDEF, REQ_RELEASE, '0, '0, 3'd6, 1'b1, ST_RELEASED, 3'd0));
    add_row(mk_row(MODE_UNDEF, REQ_SCHEDULE, '1, '1, 3'd0, 1'b1, ST_GRANTED, 3'd6));
    add_row(mk_row(MODE_WRITE, REQ_RELEASE, '0, '0, 3'd4, 1'b0, ST_GRANTED, 3'd0));

    // Reset once
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Walk the table; a mode change waits until the block has gone quiet
    foreach (directed_rows[n]) begin
      if (directed_rows[n].lock_mode != cur_mode) begin
        drain_results();
        write_lock_mode(directed_rows[n].lock_mode);
      end
      issue(directed_rows[n]);
    end

    // Random phases; each one drains and writes the mode first. The last
    // phase runs flat out with no gaps.
    run_phase(MODE_RW,    250, 1'b1);
    run_phase(MODE_WRITE, 250, 1'b1);
    run_phase(MODE_NONE,  250, 1'b1);
    run_phase(MODE_UNDEF, 250, 1'b1);
    run_phase(MODE_RW,    250, 1'b1);
    run_phase(MODE_WRITE, 250, 1'b1);
    run_phase(MODE_RW,    250, 1'b0);

    // Wait out the tail, bounded, then the drain margin for strays
    start <= 1'b0;
    n = 0;
    while (pending_outcomes.size() != 0 && n < LAST_WAIT) begin
      @(posedge clk);
      n++;
    end
    lost = (pending_outcomes.size() != 0);
    if (lost) begin
      $error("%0d expected result beats never arrived", pending_outcomes.size());
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    #1;
    if (err_cnt == 0 && !lost) begin
      $display("lock_aware_worker_dispatcher_core test passed");
    end else begin
      $display("lock_aware_worker_dispatcher_core test failed");
    end
    $finish;
  end

endmodule
